/* sv/block_layout_component_offsets_assert.svh */
// ----------------------------------------------------------------------------
// block_layout_component_offsets_assert
// Assertion macros for the component offset block, clocked on clock and
// quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef BLOCK_LAYOUT_COMPONENT_OFFSETS_ASSERT_SVH
`define BLOCK_LAYOUT_COMPONENT_OFFSETS_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define BLCO_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define BLCO_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/blco_pkg.sv */
// ----------------------------------------------------------------------------
// blco_pkg
// Shared types, shape table and constants for the std140 / std430 component
// offset block.
// ----------------------------------------------------------------------------
package blco_pkg;

   localparam logic [5:0] TYPE_COUNT    = 6'd58;
   localparam logic [6:0] VEC4_ALIGN    = 7'd16;
   localparam logic [2:0] WIDE_MINOR    = 3'd3;
   localparam logic [2:0] WIDE_MINOR_AS = 3'd4;

   typedef struct packed {
      logic [3:0] kind;
      logic [2:0] cols;
      logic [2:0] rows;
   } shape_type;

   typedef struct packed {
      logic load;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   localparam shape_type SHAPE_TABLE [TYPE_COUNT] = '{
      '{4'd0, 3'd1, 3'd1}, '{4'd1, 3'd1, 3'd1}, '{4'd2, 3'd1, 3'd1},
      '{4'd3, 3'd1, 3'd1}, '{4'd4, 3'd1, 3'd1}, '{4'd5, 3'd1, 3'd1},
      '{4'd6, 3'd1, 3'd1}, '{4'd7, 3'd1, 3'd1}, '{4'd8, 3'd1, 3'd1},
      '{4'd9, 3'd1, 3'd1},
      '{4'd8, 3'd1, 3'd2}, '{4'd8, 3'd1, 3'd3}, '{4'd8, 3'd1, 3'd4},
      '{4'd9, 3'd1, 3'd2}, '{4'd9, 3'd1, 3'd3}, '{4'd9, 3'd1, 3'd4},
      '{4'd0, 3'd1, 3'd2}, '{4'd0, 3'd1, 3'd3}, '{4'd0, 3'd1, 3'd4},
      '{4'd1, 3'd1, 3'd2}, '{4'd1, 3'd1, 3'd3}, '{4'd1, 3'd1, 3'd4},
      '{4'd2, 3'd1, 3'd2}, '{4'd2, 3'd1, 3'd3}, '{4'd2, 3'd1, 3'd4},
      '{4'd3, 3'd1, 3'd2}, '{4'd3, 3'd1, 3'd3}, '{4'd3, 3'd1, 3'd4},
      '{4'd4, 3'd1, 3'd2}, '{4'd4, 3'd1, 3'd3}, '{4'd4, 3'd1, 3'd4},
      '{4'd5, 3'd1, 3'd2}, '{4'd5, 3'd1, 3'd3}, '{4'd5, 3'd1, 3'd4},
      '{4'd6, 3'd1, 3'd2}, '{4'd6, 3'd1, 3'd3}, '{4'd6, 3'd1, 3'd4},
      '{4'd7, 3'd1, 3'd2}, '{4'd7, 3'd1, 3'd3}, '{4'd7, 3'd1, 3'd4},
      '{4'd8, 3'd2, 3'd2}, '{4'd8, 3'd2, 3'd3}, '{4'd8, 3'd2, 3'd4},
      '{4'd8, 3'd3, 3'd2}, '{4'd8, 3'd3, 3'd3}, '{4'd8, 3'd3, 3'd4},
      '{4'd8, 3'd4, 3'd2}, '{4'd8, 3'd4, 3'd3}, '{4'd8, 3'd4, 3'd4},
      '{4'd9, 3'd2, 3'd2}, '{4'd9, 3'd2, 3'd3}, '{4'd9, 3'd2, 3'd4},
      '{4'd9, 3'd3, 3'd2}, '{4'd9, 3'd3, 3'd3}, '{4'd9, 3'd3, 3'd4},
      '{4'd9, 3'd4, 3'd2}, '{4'd9, 3'd4, 3'd3}, '{4'd9, 3'd4, 3'd4}
   };

   // component size in bytes per base kind
   function automatic logic [3:0] kind_bytes(input logic [3:0] kind);
      logic [3:0] bytes;
      unique case (kind)
         4'd0, 4'd1, 4'd8: bytes = 4'd4;
         4'd2, 4'd3:       bytes = 4'd1;
         4'd4, 4'd5:       bytes = 4'd2;
         4'd6, 4'd7, 4'd9: bytes = 4'd8;
         default:          bytes = 4'd0;
      endcase
      return bytes;
   endfunction

endpackage

/* sv/blco_dpath.sv */
// ----------------------------------------------------------------------------
// blco_dpath
// Shape lookup, stride and size arithmetic, and the component offset walker.
// ----------------------------------------------------------------------------
module blco_dpath
   import blco_pkg::*;
(
   input  logic        clock,
   input  logic [5:0]  req_type_code,
   input  logic        req_layout_std,
   input  logic        req_major_axis,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [6:0]  rsp_offset,
   output logic [3:0]  rsp_base_kind,
   output logic [5:0]  rsp_stride,
   output logic [7:0]  rsp_total_size,
   output logic        rsp_error
);

   logic        code_ok;
   logic [5:0]  tab_idx;
   shape_type   shp;
   logic [3:0]  size_w;
   logic        row_maj;
   logic [2:0]  major_w;
   logic [2:0]  minor_w;
   logic [2:0]  minor_eff;
   logic [6:0]  align_w;
   logic [6:0]  rounded_w;
   logic [6:0]  stride_w;
   logic [2:0]  major_m1;
   logic [6:0]  minor_bytes;
   logic [7:0]  total_w;

   logic [3:0]  kind_ff,   kind_in;
   logic [5:0]  stride_ff, stride_in;
   logic [7:0]  total_ff,  total_in;
   logic        err_ff,    err_in;
   logic [5:0]  inner_ff,  inner_in;
   logic [5:0]  outer_ff,  outer_in;
   logic [1:0]  rmax_ff,   rmax_in;
   logic [1:0]  cmax_ff,   cmax_in;
   logic [1:0]  r_ff,      r_in;
   logic [1:0]  c_ff,      c_in;
   logic [6:0]  off_ff,    off_in;
   logic [6:0]  base_ff,   base_in;

   assign code_ok     = req_type_code < TYPE_COUNT;
   assign tab_idx     = code_ok ? req_type_code : 6'd0;
   assign shp         = SHAPE_TABLE[tab_idx];
   assign size_w      = kind_bytes(shp.kind);
   assign row_maj     = req_major_axis && (shp.cols != 3'd1);
   assign major_w     = row_maj ? shp.rows : shp.cols;
   assign minor_w     = row_maj ? shp.cols : shp.rows;
   assign minor_eff   = (minor_w == WIDE_MINOR) ? WIDE_MINOR_AS : minor_w;
   assign align_w     = {3'b0, size_w} * {4'b0, minor_eff};
   assign rounded_w   = (align_w + (VEC4_ALIGN - 7'd1)) & ~(VEC4_ALIGN - 7'd1);
   assign stride_w    = req_layout_std ? align_w : rounded_w;
   assign major_m1    = major_w - 3'd1;
   assign minor_bytes = {3'b0, size_w} * {4'b0, minor_w};
   assign total_w     = ({6'b0, major_m1[1:0]} * {2'b0, stride_w[5:0]})
                      + {1'b0, minor_bytes};

   always_comb begin
      kind_in   = kind_ff;
      stride_in = stride_ff;
      total_in  = total_ff;
      err_in    = err_ff;
      inner_in  = inner_ff;
      outer_in  = outer_ff;
      rmax_in   = rmax_ff;
      cmax_in   = cmax_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      off_in    = off_ff;
      base_in   = base_ff;
      if (cmd.load) begin
         r_in    = 2'd0;
         c_in    = 2'd0;
         off_in  = 7'd0;
         base_in = 7'd0;
         if (code_ok) begin
            kind_in   = shp.kind;
            stride_in = stride_w[5:0];
            total_in  = total_w;
            err_in    = 1'b0;
            inner_in  = row_maj ? stride_w[5:0] : {2'b0, size_w};
            outer_in  = row_maj ? {2'b0, size_w} : stride_w[5:0];
            rmax_in   = 2'(shp.rows - 3'd1);
            cmax_in   = 2'(shp.cols - 3'd1);
         end else begin
            kind_in   = 4'd0;
            stride_in = 6'd0;
            total_in  = 8'd0;
            err_in    = 1'b1;
            inner_in  = 6'd0;
            outer_in  = 6'd0;
            rmax_in   = 2'd0;
            cmax_in   = 2'd0;
         end
      end else if (cmd.advance) begin
         if (r_ff == rmax_ff) begin
            r_in    = 2'd0;
            c_in    = c_ff + 2'd1;
            base_in = base_ff + {1'b0, outer_ff};
            off_in  = base_ff + {1'b0, outer_ff};
         end else begin
            r_in    = r_ff + 2'd1;
            off_in  = off_ff + {1'b0, inner_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      stride_ff <= stride_in;
      total_ff  <= total_in;
      err_ff    <= err_in;
      inner_ff  <= inner_in;
      outer_ff  <= outer_in;
      rmax_ff   <= rmax_in;
      cmax_ff   <= cmax_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      off_ff    <= off_in;
      base_ff   <= base_in;
   end

   assign status.last    = (r_ff == rmax_ff) && (c_ff == cmax_ff);
   assign rsp_offset     = off_ff;
   assign rsp_base_kind  = kind_ff;
   assign rsp_stride     = stride_ff;
   assign rsp_total_size = total_ff;
   assign rsp_error      = err_ff;

endmodule

/* sv/blco_ctrl.sv */
// ----------------------------------------------------------------------------
// blco_ctrl
// Request / response sequencer: loads a request into the datapath and steps
// it through its components as responses are taken.
// ----------------------------------------------------------------------------
module blco_ctrl
   import blco_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  status_type  status,
   output cmd_type     cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic take;
   logic done;

   assign take      = (state_ff == ST_RUN) && !rsp_stall;
   assign done      = take && status.last;
   assign req_stall = !((state_ff == ST_IDLE) || done);
   assign rsp_valid = (state_ff == ST_RUN);

   assign cmd.load    = req_valid && !req_stall;
   assign cmd.advance = take && !status.last;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (done) state_in = cmd.load ? ST_RUN : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/block_layout_component_offsets.sv */
// ----------------------------------------------------------------------------
// block_layout_component_offsets
// Byte offset of every component of a shader scalar, vector or matrix under
// the std140 or std430 layout rules.
// ----------------------------------------------------------------------------
// A request is taken while the block is idle or in the cycle its final
// response leaves. The first response is shown in the cycle after the
// request is taken; a type gives cols * rows responses (1 to 16), one per
// cycle when the response side does not stall, stepped by the row / column
// counter in the datapath. Responses run column by column, row by row
// within a column, and the final one carries last. A type code beyond the
// table gives one response with error and last.
// ----------------------------------------------------------------------------
`include "block_layout_component_offsets_assert.svh"

module block_layout_component_offsets
   import blco_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_type_code,
   input  logic        req_layout_std,
   input  logic        req_major_axis,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_offset,
   output logic [3:0]  rsp_base_kind,
   output logic [5:0]  rsp_stride,
   output logic [7:0]  rsp_total_size,
   output logic        rsp_last,
   output logic        rsp_error
);

   cmd_type    cmd;
   status_type status;

   blco_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   blco_dpath u_dpath (
      .clock          (clock),
      .req_type_code  (req_type_code),
      .req_layout_std (req_layout_std),
      .req_major_axis (req_major_axis),
      .cmd            (cmd),
      .status         (status),
      .rsp_offset     (rsp_offset),
      .rsp_base_kind  (rsp_base_kind),
      .rsp_stride     (rsp_stride),
      .rsp_total_size (rsp_total_size),
      .rsp_error      (rsp_error)
   );

   assign rsp_last = status.last;

   `BLCO_ASSERT_NEXT(a_req_gives_rsp, req_valid && !req_stall, rsp_valid, "request without response")
   `BLCO_ASSERT_IMPLIES(a_err_single, rsp_valid && rsp_error, rsp_last && (rsp_offset == 7'd0), "error response not single")
   `BLCO_ASSERT_IMPLIES(a_off_in_size, rsp_valid && !rsp_error, {1'b0, rsp_offset} < rsp_total_size, "offset beyond size")
   `BLCO_ASSERT_IMPLIES(a_busy_stall, rsp_valid && !rsp_last, req_stall, "request taken mid value")

endmodule
